@@ rtl/core/box_blur_3x3_edge_average_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 box blur.
// Each macro checks an implication on the rising clock edge, with the check
// switched off while reset is high. Synthesis sees empty macros.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AVERAGE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("box blur assertion failed");

// Next-cycle implication.
`define BB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("box blur assertion failed");

`else

`define BB_ASSERT_NOW(label, clk, rst, ante, cons)
`define BB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/blur_pkg.sv @@
// ----------------------------------------------------------------------------
// Box blur package
// Beat types, register codes, sequencer states and the reciprocal table
// used to divide a neighborhood sum by its pixel count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blur_pkg;

   // Channel and field widths.
   localparam int CHAN_W      = 8;
   localparam int PIX_W       = 3 * CHAN_W;
   localparam int CFG_W       = 11;
   localparam int CFG_RESET   = 1024;
   localparam int CSR_IDX_W   = 1;

   // Arithmetic widths: sum of nine channels, count up to nine,
   // numerator 2*sum+count, divisor 2*count.
   localparam int SUM_W       = 12;
   localparam int CNT_W       = 4;
   localparam int NUM_W       = 13;
   localparam int DIV_W       = 5;
   localparam int RECIP_W     = 16;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = NUM_W + RECIP_W;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Pixel sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_MUL,
      ST_FIX
   } blur_state_type;

   // Input beat.
   typedef struct packed {
      logic              kind;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } blur_req_type;

   // Result beat.
   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              frame_end;
   } blur_rsp_type;

   // floor(2^16 / (2*count)) for the counts that a clipped window can have.
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] m;
      unique case (cnt)
         4'd1:    m = 16'd32768;
         4'd2:    m = 16'd16384;
         4'd3:    m = 16'd10922;
         4'd4:    m = 16'd8192;
         4'd6:    m = 16'd5461;
         4'd9:    m = 16'd3640;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/box_blur_3x3_edge_average.sv @@
// ----------------------------------------------------------------------------
// 3x3 box blur with edge-clipped averaging
// Raster RGB pixels pass through two line buffers and a 3x3 window; each
// output is the rounded mean of the neighborhood that lies inside the frame.
//
//   port group  direction  handshake        payload
//   req_        in         valid / stall    blur_req_type (kind, rgb)
//   rsp_        out        valid / stall    blur_rsp_type (rgb, frame_end)
//   csr_        in         valid / ready    index, 11-bit value
//
// A pixel that produces a result goes through these steps: accept with line buffer
// read, window update, masked sum, reciprocal multiply, rounding fix.
// A pixel with no result stops after the masked sum, an ignored flush beat at once.
// The steps are run by the one-pixel sequencer around the line buffer port.
// Reset clears state, counters and window; the line buffers are not cleared.
// A result held by rsp_stall keeps the sequencer in its last step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "box_blur_3x3_edge_average_macros.svh"

module box_blur_3x3_edge_average #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire blur_pkg::blur_req_type             req_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      blur_pkg::blur_rsp_type             rsp_data,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [blur_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [blur_pkg::CFG_W-1:0]         csr_data
);

   localparam int ColW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   localparam int RowW   = $clog2(MAX_HEIGHT + 2);
   localparam int OrowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WReset = (MAX_WIDTH < blur_pkg::CFG_RESET) ?
                           MAX_WIDTH : blur_pkg::CFG_RESET;
   localparam int HReset = (MAX_HEIGHT < blur_pkg::CFG_RESET) ?
                           MAX_HEIGHT : blur_pkg::CFG_RESET;

   localparam int CW = blur_pkg::CHAN_W;

   // Sequencer and control state.
   blur_pkg::blur_state_type state_ff, state_in;
   logic [WW-1:0]    w_ff;
   logic [HW-1:0]    h_ff;
   logic [ColW-1:0]  col_ff;
   logic [RowW-1:0]  row_ff;
   logic [ColW-1:0]  ocol_ff;
   logic [OrowW-1:0] orow_ff;
   logic             emit_ff;
   logic             last_ff;
   logic [2:0]       rowok_ff;
   logic [2:0]       colok_ff;
   logic             out_valid_ff;

   // Datapath registers.
   logic [blur_pkg::PIX_W-1:0]         pix_ff;
   logic [blur_pkg::PIX_W-1:0]         upper_rd_ff;
   logic [blur_pkg::PIX_W-1:0]         middle_rd_ff;
   logic [2:0][2:0][blur_pkg::PIX_W-1:0] win_ff;
   logic [2:0][blur_pkg::SUM_W-1:0]    sum_ff;
   logic [2:0][blur_pkg::SUM_W-1:0]    sum_in;
   logic [blur_pkg::CNT_W-1:0]         cnt_ff;
   logic [blur_pkg::CNT_W-1:0]         cnt_in;
   logic [2:0][CW-1:0]                 q0_ff;
   logic [2:0][CW-1:0]                 q0_in;
   logic [2:0][blur_pkg::NUM_W-1:0]    n_ff;
   logic [2:0][blur_pkg::NUM_W-1:0]    n_in;
   logic [blur_pkg::DIV_W-1:0]         d_ff;
   logic [2:0][CW-1:0]                 q_in;
   blur_pkg::blur_rsp_type             out_data_ff;

   // Line buffers.
   logic [blur_pkg::PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [blur_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];

   // Handshake and control decode.
   logic            req_accept;
   logic            csr_write;
   logic            frame_open;
   logic            flush_ignored;
   logic            mem_rd_en;
   logic            mem_wr_en;
   logic            out_load;
   logic            col_last;
   logic            emit_now;
   logic            orow_inner;
   logic            ocol_inner;
   logic [WW-1:0]   w_clamp;
   logic [HW-1:0]   h_clamp;
   logic [blur_pkg::PIX_W-1:0] pix_in;

   assign req_stall  = (state_ff != blur_pkg::ST_IDLE) || csr_valid;
   assign csr_ready  = (state_ff == blur_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_valid && csr_ready;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

   // Frame position decode from the input counters.
   assign frame_open    = row_ff < RowW'(h_ff);
   assign flush_ignored = req_data.kind && frame_open;
   assign col_last      = (WW'(col_ff) == (w_ff - WW'(1)));
   assign emit_now      = (row_ff >= RowW'(2)) ||
                          ((row_ff == RowW'(1)) && (col_ff != '0));

   // Whether the row below and the column to the right lie inside the frame.
   assign orow_inner = ((OrowW + 1)'(orow_ff) + (OrowW + 1)'(1)) < (OrowW + 1)'(h_ff);
   assign ocol_inner = (WW'(ocol_ff) + WW'(1)) < w_ff;

   // Pixel value: data inside the frame, zero for a drain beat.
   assign pix_in = frame_open ?
                   {req_data.blue_in, req_data.green_in, req_data.red_in} : '0;

   // Register values clipped to the legal range.
   always_comb begin
      if (csr_data == '0) begin
         w_clamp = WW'(1);
         h_clamp = HW'(1);
      end else begin
         w_clamp = (int'(csr_data) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(csr_data);
         h_clamp = (int'(csr_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(csr_data);
      end
   end

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= blur_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer next state and step strobes.
   always_comb begin
      state_in  = state_ff;
      mem_rd_en = 1'b0;
      mem_wr_en = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         blur_pkg::ST_IDLE: begin
            if (req_accept && !flush_ignored) begin
               mem_rd_en = 1'b1;
               state_in  = blur_pkg::ST_READ;
            end
         end
         blur_pkg::ST_READ: begin
            mem_wr_en = 1'b1;
            state_in  = blur_pkg::ST_SUM;
         end
         blur_pkg::ST_SUM: begin
            state_in = emit_ff ? blur_pkg::ST_MUL : blur_pkg::ST_IDLE;
         end
         blur_pkg::ST_MUL: begin
            state_in = blur_pkg::ST_FIX;
         end
         blur_pkg::ST_FIX: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = blur_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = blur_pkg::ST_IDLE;
         end
      endcase
   end

   // Line buffers: read on accept, write back the shifted column in the next cycle.
   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         upper_rd_ff  <= upper_mem[col_ff];
         middle_rd_ff <= middle_mem[col_ff];
      end
      if (mem_wr_en) begin
         upper_mem[col_ff]  <= middle_rd_ff;
         middle_mem[col_ff] <= pix_ff;
      end
   end

   // Incoming pixel held for the write-back step.
   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         pix_ff <= pix_in;
      end
   end

   // Configuration, position counters, window and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff         <= WW'(WReset);
         h_ff         <= HW'(HReset);
         col_ff       <= '0;
         row_ff       <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         win_ff       <= '0;
         emit_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rowok_ff     <= '0;
         colok_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         // A register write restarts the frame.
         if (csr_write) begin
            unique case (csr_index)
               blur_pkg::CSR_FRAME_WIDTH:  w_ff <= w_clamp;
               blur_pkg::CSR_FRAME_HEIGHT: h_ff <= h_clamp;
               default: ;
            endcase
            col_ff  <= '0;
            row_ff  <= '0;
            ocol_ff <= '0;
            orow_ff <= '0;
            win_ff  <= '0;
         end

         // Window shift, input advance and output position step.
         if (state_ff == blur_pkg::ST_READ) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= upper_rd_ff;
            win_ff[1][2] <= middle_rd_ff;
            win_ff[2][2] <= pix_ff;

            emit_ff  <= emit_now;
            last_ff  <= emit_now && !orow_inner && !ocol_inner;
            rowok_ff <= {orow_inner, 1'b1, orow_ff != '0};
            colok_ff <= {ocol_inner, 1'b1, ocol_ff != '0};

            if (emit_now && !orow_inner && !ocol_inner) begin
               // Last pixel of the frame: all counters start over.
               col_ff  <= '0;
               row_ff  <= '0;
               ocol_ff <= '0;
               orow_ff <= '0;
            end else begin
               if (col_last) begin
                  col_ff <= '0;
                  row_ff <= row_ff + RowW'(1);
               end else begin
                  col_ff <= col_ff + ColW'(1);
               end
               if (emit_now) begin
                  if (!ocol_inner) begin
                     ocol_ff <= '0;
                     orow_ff <= orow_ff + OrowW'(1);
                  end else begin
                     ocol_ff <= ocol_ff + ColW'(1);
                  end
               end
            end
         end

         // The window clears once the last sum has been taken from it.
         if ((state_ff == blur_pkg::ST_SUM) && emit_ff && last_ff) begin
            win_ff <= '0;
         end

         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Masked neighborhood sums and pixel count.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = '0;
      end
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            if (rowok_ff[r] && colok_ff[k]) begin
               for (int c = 0; c < 3; c++) begin
                  sum_in[c] = sum_in[c] + blur_pkg::SUM_W'(win_ff[r][k][c*CW +: CW]);
               end
            end
         end
      end
      cnt_in = blur_pkg::CNT_W'($countones(rowok_ff)) *
               blur_pkg::CNT_W'($countones(colok_ff));
   end

   // Estimate of (2*sum+count)/(2*count) by reciprocal multiply; low by at most one.
   always_comb begin
      logic [blur_pkg::PROD_W-1:0] prod;
      for (int c = 0; c < 3; c++) begin
         n_in[c] = blur_pkg::NUM_W'({sum_ff[c], 1'b0}) + blur_pkg::NUM_W'(cnt_ff);
         prod    = blur_pkg::PROD_W'(n_in[c]) *
                   blur_pkg::PROD_W'(blur_pkg::recip(cnt_ff));
         q0_in[c] = prod[blur_pkg::RECIP_SHIFT +: CW];
      end
   end

   // Correction step: bump the estimate when the remainder reaches the divisor.
   always_comb begin
      logic [blur_pkg::NUM_W-1:0] qd;
      logic [blur_pkg::NUM_W-1:0] rem;
      for (int c = 0; c < 3; c++) begin
         qd      = blur_pkg::NUM_W'(q0_ff[c]) * blur_pkg::NUM_W'(d_ff);
         rem     = n_ff[c] - qd;
         q_in[c] = q0_ff[c] + CW'(rem >= blur_pkg::NUM_W'(d_ff));
      end
   end

   // Arithmetic pipeline registers.
   always_ff @(posedge clock) begin
      if (state_ff == blur_pkg::ST_SUM) begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
      if (state_ff == blur_pkg::ST_MUL) begin
         q0_ff <= q0_in;
         n_ff  <= n_in;
         d_ff  <= {cnt_ff, 1'b0};
      end
      if (out_load) begin
         out_data_ff.red_out   <= q_in[0];
         out_data_ff.green_out <= q_in[1];
         out_data_ff.blue_out  <= q_in[2];
         out_data_ff.frame_end <= last_ff;
      end
   end

   // Checks on counters and the sequencer.
   `BB_ASSERT_NOW(a_col_in_row, clock, reset, 1'b1, WW'(col_ff) < w_ff)
   `BB_ASSERT_NOW(a_opos_in_frame, clock, reset, 1'b1, (WW'(ocol_ff) < w_ff) && ((OrowW + 1)'(orow_ff) < (OrowW + 1)'(h_ff)))
   `BB_ASSERT_NOW(a_count_nonzero, clock, reset, state_ff == blur_pkg::ST_MUL, cnt_ff != '0)
   `BB_ASSERT_NEXT(a_result_shown, clock, reset, out_load, rsp_valid)

endmodule

`default_nettype wire
